[rtl/crtc_pkg.sv]
package crtc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_PIXEL_MODE   = 3'd0;
  localparam logic [2:0] CFG_CHARS_LINE   = 3'd1;
  localparam logic [2:0] CFG_RASTER_M1    = 3'd2;
  localparam logic [2:0] CFG_CHAR_ROWS    = 3'd3;
  localparam logic [2:0] CFG_START_HIGH   = 3'd4;
  localparam logic [2:0] CFG_START_LOW    = 3'd5;

  // Pixel modes
  localparam logic [1:0] MODE_NIB4  = 2'd0;
  localparam logic [1:0] MODE_DUO4  = 2'd1;
  localparam logic [1:0] MODE_BIT8  = 2'd2;
  localparam logic [1:0] MODE_DUO2  = 2'd3;

  // Register reset values
  localparam logic [1:0] RST_PIXEL_MODE = 2'd1;
  localparam logic [7:0] RST_CHARS_LINE = 8'd40;
  localparam logic [2:0] RST_RASTER_M1  = 3'd7;
  localparam logic [7:0] RST_CHAR_ROWS  = 8'd25;
  localparam logic [7:0] RST_START_HIGH = 8'd48;
  localparam logic [7:0] RST_START_LOW  = 8'd0;

  typedef struct packed {
    logic [1:0] pixel_mode;
    logic [7:0] chars_per_line;
    logic [2:0] raster_lines_m1;
    logic [7:0] char_rows;
    logic [7:0] start_high;
    logic [7:0] start_low;
  } crtc_cfg_t;

  typedef logic [7:0][3:0] crtc_pix_t;

  // Spread a 4-bit pixel over the even bit positions of a byte
  function automatic logic [7:0] nib_spread(input logic [3:0] p);
    logic [7:0] v;
    v = 8'd0;
    case (p)
      4'd0:  v = 8'd0;
      4'd1:  v = 8'd64;
      4'd2:  v = 8'd4;
      4'd3:  v = 8'd68;
      4'd4:  v = 8'd16;
      4'd5:  v = 8'd80;
      4'd6:  v = 8'd20;
      4'd7:  v = 8'd84;
      4'd8:  v = 8'd1;
      4'd9:  v = 8'd65;
      4'd10: v = 8'd5;
      4'd11: v = 8'd69;
      4'd12: v = 8'd17;
      4'd13: v = 8'd81;
      4'd14: v = 8'd21;
      4'd15: v = 8'd85;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Spread a 2-bit pixel over bits 0 and 4
  function automatic logic [7:0] duo_spread(input logic [1:0] p);
    logic [7:0] v;
    v = 8'd0;
    case (p)
      2'd0: v = 8'd0;
      2'd1: v = 8'd16;
      2'd2: v = 8'd1;
      2'd3: v = 8'd17;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/crtc_in_if.sv]
interface crtc_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] pix0;
  logic [3:0] pix1;
  logic [3:0] pix2;
  logic [3:0] pix3;
  logic [3:0] pix4;
  logic [3:0] pix5;
  logic [3:0] pix6;
  logic [3:0] pix7;

  modport source (output valid, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7,
                  input ready);
  modport sink (input valid, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7,
                output ready);
endinterface

[rtl/crtc_out_if.sv]
interface crtc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mem_address;
  logic [7:0]  video_byte;
  logic        frame_last;

  modport source (output valid, mem_address, video_byte, frame_last, input ready);
  modport sink (input valid, mem_address, video_byte, frame_last, output ready);
endinterface

[rtl/crtc_screen_address_pixel_pack_unit.sv]
// Screen address generator and pixel packer.
// The result of an input transfer shows on out_ch in the cycle after it.
// Throughput: one item per cycle; the output register refills in the same
// cycle it is drained, so only a stalled sink holds off input.
// Reset (rst_n low, synchronous): scan counters clear to the frame start,
// registers take their defaults and the output register empties.
module crtc_screen_address_pixel_pack_unit
  import crtc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  crtc_in_if.sink       in_ch,
  crtc_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  crtc_cfg_t   cfg;
  crtc_pix_t   pix;
  logic        in_xfer;
  logic [15:0] mem_address;
  logic [7:0]  video_byte;
  logic        frame_last;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] mem_address_r;
  logic [7:0]  video_byte_r;
  logic        frame_last_r;

  // Take a new item whenever the output register is empty or drains now
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign pix = {in_ch.pix7, in_ch.pix6, in_ch.pix5, in_ch.pix4,
                in_ch.pix3, in_ch.pix2, in_ch.pix1, in_ch.pix0};

  crtc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Scan position advances once per transferred byte
  crtc_scan_ctr u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .advance     (in_xfer),
    .mem_address (mem_address),
    .frame_last  (frame_last)
  );

  crtc_pixel_pack u_pack (
    .pixel_mode (cfg.pixel_mode),
    .pix        (pix),
    .video_byte (video_byte)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the result on transfer, hold it while the sink stalls
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem_address_r <= mem_address;
      video_byte_r  <= video_byte;
      frame_last_r  <= frame_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mem_address = mem_address_r;
  assign out_ch.video_byte  = video_byte_r;
  assign out_ch.frame_last  = frame_last_r;

endmodule

[rtl/crtc_cfg_regs.sv]
module crtc_cfg_regs
  import crtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output crtc_cfg_t  cfg
);

  crtc_cfg_t cfg_r;
  crtc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_MODE: cfg_nxt.pixel_mode      = cfg_data[1:0];
        CFG_CHARS_LINE: cfg_nxt.chars_per_line  = cfg_data;
        CFG_RASTER_M1:  cfg_nxt.raster_lines_m1 = cfg_data[2:0];
        CFG_CHAR_ROWS:  cfg_nxt.char_rows       = cfg_data;
        CFG_START_HIGH: cfg_nxt.start_high      = cfg_data;
        CFG_START_LOW:  cfg_nxt.start_low       = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode      <= RST_PIXEL_MODE;
      cfg_r.chars_per_line  <= RST_CHARS_LINE;
      cfg_r.raster_lines_m1 <= RST_RASTER_M1;
      cfg_r.char_rows       <= RST_CHAR_ROWS;
      cfg_r.start_high      <= RST_START_HIGH;
      cfg_r.start_low       <= RST_START_LOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/crtc_pixel_pack.sv]
module crtc_pixel_pack
  import crtc_pkg::*;
(
  input  logic [1:0] pixel_mode,
  input  crtc_pix_t  pix,
  output logic [7:0] video_byte
);

  always_comb begin
    video_byte = 8'd0;
    case (pixel_mode)
      MODE_NIB4: video_byte = (nib_spread(pix[0]) << 1) | nib_spread(pix[1]);
      MODE_DUO4: video_byte = (duo_spread(pix[0][1:0]) << 3)
                            | (duo_spread(pix[1][1:0]) << 2)
                            | (duo_spread(pix[2][1:0]) << 1)
                            |  duo_spread(pix[3][1:0]);
      MODE_BIT8: video_byte = {pix[0][0], pix[1][0], pix[2][0], pix[3][0],
                               pix[4][0], pix[5][0], pix[6][0], pix[7][0]};
      MODE_DUO2: video_byte = (duo_spread(pix[0][1:0]) << 3)
                            | (duo_spread(pix[1][1:0]) << 2);
      default:   video_byte = 8'd0;
    endcase
  end

endmodule

[rtl/crtc_scan_ctr.sv]
module crtc_scan_ctr
  import crtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  crtc_cfg_t   cfg,
  input  logic        advance,
  output logic [15:0] mem_address,
  output logic        frame_last
);

  logic        byte_clock_r, byte_clock_nxt;
  logic [7:0]  column_r, column_nxt;
  logic [2:0]  raster_r, raster_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [15:0] row_base_r, row_base_nxt;

  logic [15:0] ma;
  logic        col_end, ras_end, row_end;

  assign ma = row_base_r + {8'd0, column_r} + {cfg.start_high, cfg.start_low};
  assign mem_address = {ma[13:12], raster_r, ma[9:0], byte_clock_r};

  // Zero limits behave as one
  assign col_end = ({1'b0, column_r} + 9'd1) >= {1'b0, cfg.chars_per_line};
  assign ras_end = raster_r >= cfg.raster_lines_m1;
  assign row_end = ({1'b0, row_r} + 9'd1) >= {1'b0, cfg.char_rows};
  assign frame_last = byte_clock_r && col_end && ras_end && row_end;

  always_comb begin
    byte_clock_nxt = byte_clock_r;
    column_nxt     = column_r;
    raster_nxt     = raster_r;
    row_nxt        = row_r;
    row_base_nxt   = row_base_r;
    if (advance) begin
      byte_clock_nxt = !byte_clock_r;
      if (byte_clock_r) begin
        if (!col_end) begin
          column_nxt = column_r + 8'd1;
        end else begin
          column_nxt = 8'd0;
          if (!ras_end) begin
            raster_nxt = raster_r + 3'd1;
          end else begin
            raster_nxt = 3'd0;
            if (!row_end) begin
              row_nxt      = row_r + 8'd1;
              row_base_nxt = row_base_r + {8'd0, cfg.chars_per_line};
            end else begin
              row_nxt      = 8'd0;
              row_base_nxt = 16'd0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_clock_r <= 1'b0;
      column_r     <= 8'd0;
      raster_r     <= 3'd0;
      row_r        <= 8'd0;
      row_base_r   <= 16'd0;
    end else begin
      byte_clock_r <= byte_clock_nxt;
      column_r     <= column_nxt;
      raster_r     <= raster_nxt;
      row_r        <= row_nxt;
      row_base_r   <= row_base_nxt;
    end
  end

endmodule

[tb/tb_crtc_screen_address_pixel_pack_unit.sv]
`timescale 1ns / 100ps

module tb_crtc_screen_address_pixel_pack_unit;
  import crtc_pkg::*;

  // Indexes past the register list; writes there must leave every register alone
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  // Cycles with no transfer on either channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // Longest receiver hold-off used for the backpressure test
  localparam int LONG_HOLD = 60;

  typedef struct packed {
    logic [15:0] mem_address;
    logic [7:0]  video_byte;
    logic        frame_last;
  } scan_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  crtc_in_if  in_if ();
  crtc_out_if out_if ();

  crtc_screen_address_pixel_pack_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the registers and the scan position
  crtc_cfg_t   cfg_shadow;
  logic        byte_phase;
  logic [7:0]  col_cnt;
  logic [2:0]  ras_cnt;
  logic [7:0]  row_cnt;
  logic [15:0] row_base;

  // Expected scan results, oldest first
  scan_result_t pending_scan_q[$];

  int fail_count;
  int pixel_transfers;
  int frame_ends_seen;
  int settings_count;

  // Knobs set by the tests for the stimulus and the receiver
  bit src_idle_en;
  bit sink_stall_en;
  int long_hold_req;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scan position and pixel packing predictor
  // ---------------------------------------------------------------------------
  task automatic reset_scan_model();
    cfg_shadow.pixel_mode      = RST_PIXEL_MODE;
    cfg_shadow.chars_per_line  = RST_CHARS_LINE;
    cfg_shadow.raster_lines_m1 = RST_RASTER_M1;
    cfg_shadow.char_rows       = RST_CHAR_ROWS;
    cfg_shadow.start_high      = RST_START_HIGH;
    cfg_shadow.start_low       = RST_START_LOW;
    byte_phase = 1'b0;
    col_cnt    = 8'd0;
    ras_cnt    = 3'd0;
    row_cnt    = 8'd0;
    row_base   = 16'd0;
  endtask

  // Pack the pixels of one screen byte; unused pixels and unused high bits drop out
  function automatic logic [7:0] pack_byte(input crtc_pix_t p);
    logic [7:0] v;
    case (cfg_shadow.pixel_mode)
      // two 4-bit pixels, bits interleaved: left pixel on the odd positions
      MODE_NIB4: v = {p[0][0], p[1][0], p[0][2], p[1][2],
                      p[0][1], p[1][1], p[0][3], p[1][3]};
      // four 2-bit pixels: low bits in the upper nibble, high bits in the lower
      MODE_DUO4: v = {p[0][0], p[1][0], p[2][0], p[3][0],
                      p[0][1], p[1][1], p[2][1], p[3][1]};
      // eight 1-bit pixels, leftmost in the MSB
      MODE_BIT8: v = {p[0][0], p[1][0], p[2][0], p[3][0],
                      p[4][0], p[5][0], p[6][0], p[7][0]};
      // two 2-bit pixels in the left slots of the four-pixel layout
      default:   v = {p[0][0], p[1][0], 2'b00, p[0][1], p[1][1], 2'b00};
    endcase
    return v;
  endfunction

  // Work out the result of one transfer and advance the scan position
  function automatic scan_result_t predict_scan(input crtc_pix_t p);
    scan_result_t r;
    logic [15:0]  ma;
    logic         col_end;
    logic         ras_end;
    logic         row_end;
    ma = row_base + 16'(col_cnt) + {cfg_shadow.start_high, 8'h00}
         + 16'(cfg_shadow.start_low);
    r.mem_address = {ma[13:12], ras_cnt, ma[9:0], byte_phase};
    r.video_byte  = pack_byte(p);

    // Compare in nine bits so a zero limit behaves like one and a counter
    // left past a lowered limit wraps at its next step
    col_end = (9'(col_cnt) + 9'd1) >= 9'(cfg_shadow.chars_per_line);
    ras_end = ras_cnt >= cfg_shadow.raster_lines_m1;
    row_end = (9'(row_cnt) + 9'd1) >= 9'(cfg_shadow.char_rows);
    r.frame_last = byte_phase && col_end && ras_end && row_end;

    if (!byte_phase) begin
      byte_phase = 1'b1;
    end else begin
      byte_phase = 1'b0;
      if (!col_end) begin
        col_cnt = col_cnt + 8'd1;
      end else begin
        col_cnt = 8'd0;
        if (!ras_end) begin
          ras_cnt = ras_cnt + 3'd1;
        end else begin
          ras_cnt = 3'd0;
          if (!row_end) begin
            row_cnt  = row_cnt + 8'd1;
            row_base = row_base + 16'(cfg_shadow.chars_per_line);
          end else begin
            row_cnt  = 8'd0;
            row_base = 16'd0;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic crtc_pix_t random_pixels();
    crtc_pix_t p;
    for (int i = 0; i < 8; i++) p[i] = 4'($urandom_range(0, 15));
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // Offer one screen byte; return once it has transferred. Valid stays high so
  // the next call can follow back to back; drain() drops it.
  task automatic send_pixels(input crtc_pix_t p);
    int gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.pix0  = p[0];
    in_if.pix1  = p[1];
    in_if.pix2  = p[2];
    in_if.pix3  = p[3];
    in_if.pix4  = p[4];
    in_if.pix5  = p[5];
    in_if.pix6  = p[6];
    in_if.pix7  = p[7];
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_scan_q.push_back(predict_scan(p));
    pixel_transfers++;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle
  // before anything else touches the block
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_scan_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write; only called with the block drained
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      CFG_PIXEL_MODE: cfg_shadow.pixel_mode      = data[1:0];
      CFG_CHARS_LINE: cfg_shadow.chars_per_line  = data;
      CFG_RASTER_M1:  cfg_shadow.raster_lines_m1 = data[2:0];
      CFG_CHAR_ROWS:  cfg_shadow.char_rows       = data;
      CFG_START_HIGH: cfg_shadow.start_high      = data;
      CFG_START_LOW:  cfg_shadow.start_low       = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_setting(input logic [1:0] mode, input logic [7:0] chars,
                                 input logic [2:0] rlm1, input logic [7:0] rows,
                                 input logic [7:0] sh, input logic [7:0] sl);
    write_reg(CFG_PIXEL_MODE, {6'b0, mode});
    write_reg(CFG_CHARS_LINE, chars);
    write_reg(CFG_RASTER_M1, {5'b0, rlm1});
    write_reg(CFG_CHAR_ROWS, rows);
    write_reg(CFG_START_HIGH, sh);
    write_reg(CFG_START_LOW, sl);
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All-zero, all-ones and alternating pixels in every mode; the mode register
  // is written with junk in its upper bits to check they are dropped
  task automatic test_pixel_extremes();
    logic [1:0] mode;
    for (int m = 0; m < 4; m++) begin
      mode = 2'(m);
      write_reg(CFG_PIXEL_MODE, {6'b101101, mode});
      settings_count++;
      send_pixels('0);
      send_pixels('1);
      send_pixels({4{4'hA, 4'h5}});
      drain();
    end
  endtask

  // One column, one raster line, one row: every second byte ends the frame.
  // Then zero columns and zero rows, which must behave as one.
  task automatic test_tiny_frame();
    program_setting(MODE_BIT8, 8'd1, 3'd0, 8'd1, 8'h12, 8'h34);
    repeat (3) send_pixels(random_pixels());
    drain();
    write_reg(CFG_CHARS_LINE, 8'd0);
    write_reg(CFG_CHAR_ROWS, 8'd0);
    repeat (3) send_pixels(random_pixels());
    drain();
  endtask

  // Writes to indexes past the list change nothing
  task automatic test_spare_index();
    write_reg(CFG_SPARE_6, 8'hFF);
    write_reg(CFG_SPARE_7, 8'h00);
    repeat (2) send_pixels(random_pixels());
    drain();
  endtask

  // Run the counters up, then lower the limits below them so they wrap
  // at their next step; row_base keeps its sum across the change
  task automatic test_limit_shrink();
    program_setting(MODE_NIB4, 8'd2, 3'd7, 8'd3, 8'h3F, 8'hF0);
    repeat (9) send_pixels(random_pixels());
    drain();
    write_reg(CFG_RASTER_M1, 8'd1);
    write_reg(CFG_CHARS_LINE, 8'd1);
    repeat (4) send_pixels(random_pixels());
    drain();
  endtask

  // Phases of random settings, mostly small screens so frames wrap often;
  // the first two phases take the register extremes
  task automatic test_random_settings();
    logic [7:0] chars;
    logic [7:0] rows;
    int         n;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: program_setting(MODE_DUO2, 8'd255, 3'd7, 8'd255, 8'hFF, 8'hFF);
        1: program_setting(MODE_NIB4, 8'd0, 3'd0, 8'd0, 8'h00, 8'h00);
        default: begin
          chars = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, 255))
                                              : 8'($urandom_range(0, 4));
          rows  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 255))
                                              : 8'($urandom_range(0, 3));
          program_setting(2'($urandom_range(0, 3)), chars, 3'($urandom_range(0, 7)),
                          rows, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
      endcase
      // every fourth phase runs with no idling at all
      src_idle_en   = (ph % 4) != 3;
      sink_stall_en = (ph % 4) != 3;
      n = $urandom_range(25, 45);
      repeat (n) send_pixels(random_pixels());
      drain();
    end
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming, so the
  // output register fills and input ready drops
  task automatic test_backpressure();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    long_hold_req = LONG_HOLD;
    repeat (24) send_pixels(random_pixels());
    drain();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_steady_stream();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    program_setting(2'($urandom_range(0, 3)), 8'd3, 3'd1, 8'd2,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    repeat (80) send_pixels(random_pixels());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int  hold_left;
    int  burst_left;
    logic rdy;
    hold_left    = 0;
    burst_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req > 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (sink_stall_en && burst_left == 0 && $urandom_range(0, 5) == 0)
          burst_left = $urandom_range(1, 11);
        if (burst_left > 0) begin
          burst_left--;
          rdy = 1'b0;
        end else begin
          rdy = rst_n;
        end
      end
      out_if.ready = rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each output transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    scan_result_t exp_r;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (out_if.frame_last === 1'b1) frame_ends_seen++;
      if (pending_scan_q.size() == 0) begin
        $error("result with nothing expected: mem_address %h video_byte %h frame_last %b",
               out_if.mem_address, out_if.video_byte, out_if.frame_last);
        fail_count++;
      end else begin
        exp_r = pending_scan_q.pop_front();
        if (out_if.mem_address !== exp_r.mem_address) begin
          $error("mem_address expected %h actual %h", exp_r.mem_address, out_if.mem_address);
          fail_count++;
        end
        if (out_if.video_byte !== exp_r.video_byte) begin
          $error("video_byte expected %h actual %h", exp_r.video_byte, out_if.video_byte);
          fail_count++;
        end
        if (out_if.frame_last !== exp_r.frame_last) begin
          $error("frame_last expected %b actual %b", exp_r.frame_last, out_if.frame_last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no transfer happens for too long
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_scan_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // drive every input to a known value from time zero
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PIXEL_MODE;
    cfg_data      = 8'd0;
    in_if.valid   = 1'b0;
    in_if.pix0    = 4'd0;
    in_if.pix1    = 4'd0;
    in_if.pix2    = 4'd0;
    in_if.pix3    = 4'd0;
    in_if.pix4    = 4'd0;
    in_if.pix5    = 4'd0;
    in_if.pix6    = 4'd0;
    in_if.pix7    = 4'd0;
    fail_count      = 0;
    pixel_transfers = 0;
    frame_ends_seen = 0;
    settings_count  = 0;
    long_hold_req   = 0;
    src_idle_en     = 1'b1;
    sink_stall_en   = 1'b1;
    reset_scan_model();

    // hold reset, then release it away from the active edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_pixel_extremes();
    test_tiny_frame();
    test_spare_index();
    test_limit_shrink();
    test_random_settings();
    test_backpressure();
    test_steady_stream();

    // let any stray result show up after the last expected one
    repeat (4) @(posedge clk);
    if (pending_scan_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_scan_q.size());
      fail_count++;
    end

    $display("Covered %0d screen byte transfers over %0d register settings,",
             pixel_transfers, settings_count);
    $display("all four pixel modes, %0d frame wraps, stalls and a long output hold-off.",
             frame_ends_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/crtc_pkg.sv
rtl/crtc_in_if.sv
rtl/crtc_out_if.sv
rtl/crtc_cfg_regs.sv
rtl/crtc_pixel_pack.sv
rtl/crtc_scan_ctr.sv
rtl/crtc_screen_address_pixel_pack_unit.sv
tb/tb_crtc_screen_address_pixel_pack_unit.sv
